### sv/calendar_date_add_subtract_days_unit_assert.svh
// Assertion macros for the calendar date add/subtract unit.
// Each macro takes a label, the clock, the reset and the expressions.
`ifndef CALENDAR_DATE_ADD_SUBTRACT_DAYS_UNIT_ASSERT_SVH
`define CALENDAR_DATE_ADD_SUBTRACT_DAYS_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("same-cycle check failed");
`define ASSERT_NEXT(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("next-cycle check failed");
`else
`define ASSERT_IMPL(lbl, clk, rst, a, b)
`define ASSERT_NEXT(lbl, clk, rst, a, b)
`endif
`endif

### sv/cdas_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cdas_pkg
// Shared types, codes and calendar helper functions for the date unit.
// ---------------------------------------------------------------------------
package cdas_pkg;

  localparam int unsigned DEFAULT_QUEUE_DEPTH = 2;
  localparam logic [14:0] YEAR_MAX = 15'h7FFF;
  localparam logic [3:0]  MONTHS   = 4'd12;

  typedef enum logic {
    CMD_ADD = 1'b0,
    CMD_SUB = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_DATE = 2'd1,
    ST_RANGE    = 2'd2
  } status_t;

  // One classified beat waiting between the front and the walker.
  typedef struct packed {
    cmd_t        cmd;
    logic        bad;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [14:0] year;
    logic [14:0] count;
  } cdas_item_t;

  typedef struct packed {
    logic empty;
    logic full;
  } cdas_qstat_t;

  typedef struct packed {
    logic busy;
    logic load;
    logic write;
  } cdas_wstat_t;

  // Gregorian leap test. Divisibility by 25 uses a reciprocal multiply:
  // floor(y * 5243 / 2^17) equals floor(y / 25) for every 15-bit year.
  function automatic logic is_leap(input logic [14:0] y);
    logic [31:0] prod;
    logic [14:0] q;
    logic [14:0] r;
    logic        leap;
    prod = 32'(y) * 32'd5243;
    q    = prod[31:17];
    r    = y - ((q << 4) + (q << 3) + q);
    if (y[1:0] != 2'd0) begin
      leap = 1'b0;
    end else if (r != 15'd0) begin
      leap = 1'b1;
    end else begin
      leap = (y[3:0] == 4'd0);
    end
    return leap;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

### sv/cdas_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cdas_front
// Accepts input beats, checks the starting date and writes a classified
// entry into the queue.
// ---------------------------------------------------------------------------
module cdas_front import cdas_pkg::*; (
  input  logic        push,
  output logic        full,
  input  logic        command,
  input  logic [4:0]  start_day,
  input  logic [3:0]  start_month,
  input  logic [14:0] start_year,
  input  logic [14:0] day_count,
  input  cdas_qstat_t qstat,
  output logic        q_wr,
  output cdas_item_t  q_item
);

  logic [4:0] mlen;
  logic       bad;

  assign mlen = month_len(start_month, is_leap(start_year));
  assign bad  = (start_month == 4'd0) || (start_month > MONTHS) ||
                (start_day == 5'd0) || (start_day > mlen);

  assign full = qstat.full;
  assign q_wr = push && !qstat.full;

  always_comb begin
    q_item.cmd   = cmd_t'(command);
    q_item.bad   = bad;
    q_item.day   = start_day;
    q_item.month = start_month;
    q_item.year  = start_year;
    q_item.count = day_count;
  end

endmodule

### sv/cdas_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cdas_queue
// Short register queue that decouples the front from the walker.
// ---------------------------------------------------------------------------
module cdas_queue import cdas_pkg::*; #(
  parameter int unsigned DEPTH = DEFAULT_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr,
  input  cdas_item_t  wr_item,
  input  logic        rd,
  output cdas_item_t  rd_item,
  output cdas_qstat_t qstat
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  cdas_item_t    slots [DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [CW-1:0] level;
  logic          do_wr;
  logic          do_rd;

  assign qstat.empty = (level == CW'(0));
  assign qstat.full  = (level == CW'(DEPTH));
  assign do_wr       = wr && !qstat.full;
  assign do_rd       = rd && !qstat.empty;
  assign rd_item     = slots[rptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      level <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + PW'(1);
      end
      if (do_rd) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + PW'(1);
      end
      if (do_wr && !do_rd) begin
        level <= level + CW'(1);
      end else if (do_rd && !do_wr) begin
        level <= level - CW'(1);
      end
    end
  end

endmodule

### sv/cdas_walk.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cdas_walk
// Walks a date forward or backward one month border per cycle and holds
// the finished result in an output register until it is popped.
// ---------------------------------------------------------------------------
module cdas_walk import cdas_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  cdas_item_t  q_item,
  output logic        q_take,
  output logic        out_valid,
  input  logic        out_pop,
  output logic [4:0]  out_day,
  output logic [3:0]  out_month,
  output logic [14:0] out_year,
  output status_t     out_status,
  output cdas_wstat_t wstat
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t      state;
  cmd_t        cmd;
  logic [4:0]  day;
  logic [3:0]  month;
  logic [14:0] year;
  logic [14:0] count;
  status_t     st;

  logic [4:0]  day_next;
  logic [3:0]  month_next;
  logic [14:0] year_next;
  logic [14:0] count_next;
  logic        range_err;
  logic        leap;
  logic [4:0]  maxd;
  logic [15:0] sum;
  logic        wr_out;

  assign leap = is_leap(year);
  assign maxd = month_len(month, leap);
  assign sum  = 16'(day) + 16'(count);

  // One step: finish inside this month, or cross one month border.
  always_comb begin
    day_next   = day;
    month_next = month;
    year_next  = year;
    count_next = count;
    range_err  = 1'b0;
    if (cmd == CMD_ADD) begin
      if (sum <= 16'(maxd)) begin
        day_next   = sum[4:0];
        count_next = '0;
      end else begin
        count_next = count - 15'(maxd) + 15'(day) - 15'd1;
        day_next   = 5'd1;
        if (month == MONTHS) begin
          month_next = 4'd1;
          if (year == YEAR_MAX) begin
            range_err = 1'b1;
          end else begin
            year_next = year + 15'd1;
          end
        end else begin
          month_next = month + 4'd1;
        end
      end
    end else begin
      if (16'(day) > 16'(count)) begin
        day_next   = day - count[4:0];
        count_next = '0;
      end else begin
        count_next = count - 15'(day);
        if (month == 4'd1) begin
          // Stepping back over New Year lands in December.
          month_next = MONTHS;
          day_next   = month_len(MONTHS, 1'b0);
          if (year == 15'd0) begin
            range_err = 1'b1;
          end else begin
            year_next = year - 15'd1;
          end
        end else begin
          month_next = month - 4'd1;
          day_next   = month_len(month - 4'd1, leap);
        end
      end
    end
  end

  assign q_take = (state == S_IDLE) && q_valid;
  assign wr_out = (state == S_DONE) && (!out_valid || out_pop);

  assign wstat.busy  = (state != S_IDLE);
  assign wstat.load  = q_take;
  assign wstat.write = wr_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (wr_out) begin
        out_valid <= 1'b1;
      end else if (out_pop) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            state <= q_item.bad ? S_DONE : S_RUN;
          end
        end
        S_RUN: begin
          if (count == 15'd0 || range_err) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (wr_out) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_take) begin
      cmd   <= q_item.cmd;
      day   <= q_item.day;
      month <= q_item.month;
      year  <= q_item.year;
      count <= q_item.count;
      st    <= q_item.bad ? ST_BAD_DATE : ST_OK;
    end else if (state == S_RUN && count != 15'd0) begin
      if (range_err) begin
        st <= ST_RANGE;
      end else begin
        day   <= day_next;
        month <= month_next;
        year  <= year_next;
        count <= count_next;
      end
    end
  end

  // Any error reports an all-zero date.
  always_ff @(posedge clk) begin
    if (wr_out) begin
      out_status <= st;
      out_day    <= (st == ST_OK) ? day : 5'd0;
      out_month  <= (st == ST_OK) ? month : 4'd0;
      out_year   <= (st == ST_OK) ? year : 15'd0;
    end
  end

endmodule

### sv/calendar_date_add_subtract_days_unit.sv
`timescale 1ns / 1ps
// Flow: an accepted beat is written into the queue and loaded by the walker once it is idle;
// the walker then takes one walk step per month border crossed plus, where days remain, a
// last step inside the month, then passes its finish state and writes the output register.
// Invalid dates skip the walk. The walker loads a new item only when back in idle, and it
// waits in its finish state while an unpopped result holds the output register.
// Reset: synchronous, active high; empties the queue, idles the walker, clears valid.
// ---------------------------------------------------------------------------
// calendar_date_add_subtract_days_unit
// Adds a day count to a Gregorian date or subtracts it, with status.
// ---------------------------------------------------------------------------
`include "calendar_date_add_subtract_days_unit_assert.svh"
module calendar_date_add_subtract_days_unit import cdas_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        command,
  input  logic [4:0]  start_day,
  input  logic [3:0]  start_month,
  input  logic [14:0] start_year,
  input  logic [14:0] day_count,
  output logic        empty,
  input  logic        pop,
  output logic [4:0]  result_day,
  output logic [3:0]  result_month,
  output logic [14:0] result_year,
  output logic [1:0]  status
);

  cdas_qstat_t qstat;
  cdas_wstat_t wstat;
  cdas_item_t  wr_item;
  cdas_item_t  rd_item;
  logic        q_wr;
  logic        q_take;
  logic        out_valid;
  status_t     out_status;
  logic        res_err;
  logic        res_ok;
  logic        res_zero;
  logic        res_date_ok;

  cdas_front u_front (
    .push        (push),
    .full        (full),
    .command     (command),
    .start_day   (start_day),
    .start_month (start_month),
    .start_year  (start_year),
    .day_count   (day_count),
    .qstat       (qstat),
    .q_wr        (q_wr),
    .q_item      (wr_item)
  );

  cdas_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_wr),
    .wr_item (wr_item),
    .rd      (q_take),
    .rd_item (rd_item),
    .qstat   (qstat)
  );

  cdas_walk u_walk (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (!qstat.empty),
    .q_item     (rd_item),
    .q_take     (q_take),
    .out_valid  (out_valid),
    .out_pop    (pop),
    .out_day    (result_day),
    .out_month  (result_month),
    .out_year   (result_year),
    .out_status (out_status),
    .wstat      (wstat)
  );

  assign empty  = !out_valid;
  assign status = out_status;

  assign res_err     = !empty && (status != ST_OK);
  assign res_ok      = !empty && (status == ST_OK);
  assign res_zero    = (result_day == 5'd0) && (result_month == 4'd0) &&
                       (result_year == 15'd0);
  assign res_date_ok = (result_month >= 4'd1) && (result_month <= MONTHS) &&
                       (result_day >= 5'd1);

  `ASSERT_IMPL(a_err_zero, clk, rst, res_err, res_zero)
  `ASSERT_IMPL(a_ok_date, clk, rst, res_ok, res_date_ok)
  `ASSERT_IMPL(a_take_nonempty, clk, rst, wstat.load, !qstat.empty)
  `ASSERT_IMPL(a_load_idle, clk, rst, wstat.load, !wstat.busy)
  `ASSERT_NEXT(a_pop_drain, clk, rst, pop && !empty && !wstat.write, empty)

endmodule
